### design/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants of the MAC subheader parser: classified item,
// parse phases, status codes and register indexes.
// ----------------------------------------------------------------------------
package msp_pkg;

    // Most SDUs reported for one PDU before the parse ends with an error
    localparam int MAX_SDUS   = 16;
    localparam int SDU_CNT_W  = $clog2(MAX_SDUS + 1);

    // Depth of the queue between front and back
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    // Configuration register reset values
    localparam logic [5:0] DATA_LIMIT_RST = 6'd11;
    localparam logic [4:0] PAD_LCID_RST   = 5'd31;

    // Bit positions of the subheader fields
    localparam int E_BIT = 5;
    localparam int F_BIT = 7;

    localparam logic [7:0]  BYTES_MAX = 8'hFF;
    localparam logic [16:0] SUM_MAX   = 17'h1FFFF;

    // Configuration register indexes
    typedef enum logic {
        CFG_DATA_LIMIT = 1'b0,
        CFG_PAD_LCID   = 1'b1
    } t_cfg_index;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNSUPPORTED = 2'd1,
        ST_UNDERFLOW   = 2'd2,
        ST_TOO_MANY    = 2'd3
    } t_status;

    // Parse phases
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_SUB  = 4'b0010,
        PH_LEN1 = 4'b0100,
        PH_LEN2 = 4'b1000
    } t_phase;

    // Header byte with the LCID class worked out by the front
    typedef struct packed {
        logic [7:0]  header_byte;
        logic        pdu_start;
        logic [15:0] block_length;
        logic        is_data;
        logic        is_pad;
    } t_msp_item;

endpackage

### design/msp_front.sv
// ----------------------------------------------------------------------------
// msp_front
// Holds the configuration registers, accepts header bytes and classifies
// their LCID field before pushing them into the queue.
// ----------------------------------------------------------------------------
module msp_front import msp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [5:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_header_byte,
    input  logic        i_pdu_start,
    input  logic [15:0] i_block_length,
    input  logic        i_full,
    output logic        o_push,
    output t_msp_item   o_item
);

    logic [5:0] r_data_limit;
    logic [4:0] r_pad_lcid;
    logic [4:0] lcid;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_limit <= DATA_LIMIT_RST;
            r_pad_lcid   <= PAD_LCID_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_DATA_LIMIT: r_data_limit <= i_cfg_data;
                CFG_PAD_LCID:   r_pad_lcid   <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Classify the LCID; only meaningful on subheader bytes
    assign lcid                = i_header_byte[4:0];
    assign o_item.header_byte  = i_header_byte;
    assign o_item.pdu_start    = i_pdu_start;
    assign o_item.block_length = i_block_length;
    assign o_item.is_data      = {1'b0, lcid} < r_data_limit;
    assign o_item.is_pad       = lcid == r_pad_lcid;

    // Accept whenever the queue has room
    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

endmodule

### design/msp_queue.sv
// ----------------------------------------------------------------------------
// msp_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module msp_queue import msp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_msp_item i_item,
    input  logic      i_pop,
    output t_msp_item o_item,
    output logic      o_full,
    output logic      o_empty
);

    t_msp_item          r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == QDEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == QDEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_item  = r_mem[r_rd_ptr];
    assign o_full  = r_count == QCNT_W'(QDEPTH);
    assign o_empty = r_count == '0;

    // Occupancy stays within depth, and neither side misuses the queue
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= QDEPTH)
        else $error("queue occupancy above depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");

endmodule

### design/msp_back.sv
// ----------------------------------------------------------------------------
// msp_back
// Runs the subheader parse over queued items and holds each result in an
// output register until it is taken.
// ----------------------------------------------------------------------------
module msp_back import msp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_msp_item   i_item,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_sdu_valid,
    output logic [4:0]  o_channel_id,
    output logic [15:0] o_sdu_length,
    output logic [3:0]  o_sdu_index,
    output logic        o_header_done,
    output logic [7:0]  o_header_bytes,
    output logic [1:0]  o_parse_status
);

    t_phase                r_phase, n_phase, b_phase;
    logic [4:0]            r_chan, n_chan, b_chan;
    logic [6:0]            r_hi, n_hi, b_hi;
    logic [7:0]            r_bytes, n_bytes, b_bytes, bytes_inc;
    logic [16:0]           r_sum, n_sum, b_sum;
    logic [SDU_CNT_W-1:0]  r_count, n_count, b_count;
    logic [15:0]           r_blen, n_blen, b_blen;

    logic                  r_out_valid;
    logic                  r_out_sdu;
    logic [4:0]            r_out_chan;
    logic [15:0]           r_out_len;
    logic [3:0]            r_out_idx;
    logic                  r_out_done;
    logic [7:0]            r_out_bytes;
    t_status               r_out_status;

    logic                  res_valid, res_sdu, res_done, do_add;
    logic [15:0]           res_len, add_len, len_imp;
    t_status               res_status;
    logic [4:0]            lcid;
    logic [17:0]           need_sum, diff_imp, sum_add;

    // Take the next item when the output register is free or being emptied
    assign o_pop = !i_empty && (!r_out_valid || !i_out_stall);

    // Apply a restart before the step
    assign b_phase = i_item.pdu_start ? PH_SUB : r_phase;
    assign b_chan  = i_item.pdu_start ? '0 : r_chan;
    assign b_hi    = i_item.pdu_start ? '0 : r_hi;
    assign b_bytes = i_item.pdu_start ? '0 : r_bytes;
    assign b_sum   = i_item.pdu_start ? '0 : r_sum;
    assign b_count = i_item.pdu_start ? '0 : r_count;
    assign b_blen  = i_item.pdu_start ? i_item.block_length : r_blen;

    assign lcid      = i_item.header_byte[4:0];
    assign bytes_inc = (b_bytes != BYTES_MAX) ? b_bytes + 1'b1 : b_bytes;
    assign need_sum  = {10'b0, bytes_inc} + {1'b0, b_sum};
    assign diff_imp  = {2'b0, b_blen} - need_sum;
    assign len_imp   = diff_imp[15:0];
    assign sum_add   = {1'b0, b_sum} + {2'b0, add_len};

    // Step the parse on one byte
    always_comb begin
        n_phase    = r_phase;
        n_chan     = r_chan;
        n_hi       = r_hi;
        n_bytes    = r_bytes;
        n_sum      = r_sum;
        n_count    = r_count;
        n_blen     = r_blen;
        res_valid  = 1'b0;
        res_sdu    = 1'b0;
        res_len    = '0;
        res_done   = 1'b0;
        res_status = ST_OK;
        add_len    = '0;
        do_add     = 1'b0;
        if (o_pop && b_phase != PH_IDLE) begin
            n_phase = b_phase;
            n_chan  = b_chan;
            n_hi    = b_hi;
            n_bytes = bytes_inc;
            n_sum   = b_sum;
            n_count = b_count;
            n_blen  = b_blen;
            unique case (b_phase)
                PH_SUB: begin
                    if (i_item.is_data) begin
                        if (b_count >= SDU_CNT_W'(MAX_SDUS)) begin
                            n_phase    = PH_IDLE;
                            res_valid  = 1'b1;
                            res_done   = 1'b1;
                            res_status = ST_TOO_MANY;
                        end else if (i_item.header_byte[E_BIT]) begin
                            n_chan  = lcid;
                            n_phase = PH_LEN1;
                        end else if (need_sum > {2'b0, b_blen}) begin
                            n_phase    = PH_IDLE;
                            res_valid  = 1'b1;
                            res_done   = 1'b1;
                            res_status = ST_UNDERFLOW;
                        end else begin
                            n_phase   = PH_IDLE;
                            res_valid = 1'b1;
                            res_sdu   = 1'b1;
                            res_done  = 1'b1;
                            res_len   = len_imp;
                            add_len   = len_imp;
                            do_add    = 1'b1;
                        end
                    end else if (i_item.is_pad) begin
                        // Padding with E set is skipped; without it ends the header
                        if (!i_item.header_byte[E_BIT]) begin
                            n_phase   = PH_IDLE;
                            res_valid = 1'b1;
                            res_done  = 1'b1;
                        end
                    end else begin
                        n_phase    = PH_IDLE;
                        res_valid  = 1'b1;
                        res_done   = 1'b1;
                        res_status = ST_UNSUPPORTED;
                    end
                end
                PH_LEN1: begin
                    if (i_item.header_byte[F_BIT]) begin
                        n_hi    = i_item.header_byte[6:0];
                        n_phase = PH_LEN2;
                    end else begin
                        n_phase   = PH_SUB;
                        res_valid = 1'b1;
                        res_sdu   = 1'b1;
                        res_len   = {9'b0, i_item.header_byte[6:0]};
                        add_len   = res_len;
                        do_add    = 1'b1;
                    end
                end
                PH_LEN2: begin
                    n_phase   = PH_SUB;
                    res_valid = 1'b1;
                    res_sdu   = 1'b1;
                    res_len   = {1'b0, b_hi, i_item.header_byte};
                    add_len   = res_len;
                    do_add    = 1'b1;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
            // Accumulate lengths, saturating
            if (do_add) begin
                n_sum   = sum_add[17] ? SUM_MAX : sum_add[16:0];
                n_count = b_count + 1'b1;
            end
        end
    end

    // Hold parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_chan  <= '0;
            r_hi    <= '0;
            r_bytes <= '0;
            r_sum   <= '0;
            r_count <= '0;
            r_blen  <= '0;
        end else begin
            r_phase <= n_phase;
            r_chan  <= n_chan;
            r_hi    <= n_hi;
            r_bytes <= n_bytes;
            r_sum   <= n_sum;
            r_count <= n_count;
            r_blen  <= n_blen;
        end
    end

    // Output valid: load on a result, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out_sdu    <= res_sdu;
            r_out_chan   <= (b_phase == PH_SUB) ? lcid : b_chan;
            r_out_len    <= res_len;
            r_out_idx    <= b_count[3:0];
            r_out_done   <= res_done;
            r_out_bytes  <= bytes_inc;
            r_out_status <= res_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sdu_valid    = r_out_sdu;
    assign o_channel_id   = r_out_chan;
    assign o_sdu_length   = r_out_len;
    assign o_sdu_index    = r_out_idx;
    assign o_header_done  = r_out_done;
    assign o_header_bytes = r_out_bytes;
    assign o_parse_status = r_out_status;

    // A final result leaves the parse idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res_done) |=> (r_phase == PH_IDLE))
        else $error("parse still running after final result");
    // The SDU count never passes its limit
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SDU_CNT_W'(MAX_SDUS))
        else $error("SDU count above limit");
    // End-only results carry no length and errors always end the header
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_sdu) |-> (r_out_len == '0 && r_out_done))
        else $error("malformed end-only result");

endmodule

### design/mac_subheader_parser.sv
// An accepted header byte goes through a queue write, then one parse step
// into the output register. The parse step keeps running sums.
// Throughput: one header byte per cycle unless a stall holds the flow.
// A 4-entry queue parts the input side from the result register.
// Reset (synchronous, active low) idles the parse, empties the queue and the
// output, and loads the configuration registers with their reset values.
// ----------------------------------------------------------------------------
// mac_subheader_parser
// Top level: parses MAC PDU subheaders byte by byte and reports one result
// per SDU or header end, with the header size and a parse status.
// ----------------------------------------------------------------------------
module mac_subheader_parser import msp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [5:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_header_byte,
    input  logic        i_pdu_start,
    input  logic [15:0] i_block_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_sdu_valid,
    output logic [4:0]  o_channel_id,
    output logic [15:0] o_sdu_length,
    output logic [3:0]  o_sdu_index,
    output logic        o_header_done,
    output logic [7:0]  o_header_bytes,
    output logic [1:0]  o_parse_status
);

    t_msp_item push_item;
    t_msp_item head_item;
    logic      push;
    logic      pop;
    logic      full;
    logic      empty;

    // Accept and classify
    msp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_header_byte  (i_header_byte),
        .i_pdu_start    (i_pdu_start),
        .i_block_length (i_block_length),
        .i_full         (full),
        .o_push         (push),
        .o_item         (push_item)
    );

    // Buffer classified items
    msp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_full  (full),
        .o_empty (empty)
    );

    // Parse and deliver results
    msp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (head_item),
        .i_empty        (empty),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_sdu_valid    (o_sdu_valid),
        .o_channel_id   (o_channel_id),
        .o_sdu_length   (o_sdu_length),
        .o_sdu_index    (o_sdu_index),
        .o_header_done  (o_header_done),
        .o_header_bytes (o_header_bytes),
        .o_parse_status (o_parse_status)
    );

endmodule
